// ===== rtl/dbl_pkg.sv =====
// Shared types, codes and arithmetic helpers for the dimmer button and link controller.
// Used by every module in rtl; depends on nothing else.
`timescale 1ns / 1ps
package dbl_pkg;

  // Input item codes.
  localparam logic [1:0] ACT_TICK      = 2'd0;
  localparam logic [1:0] ACT_LINK_BYTE = 2'd1;
  localparam logic [1:0] ACT_SET_POWER = 2'd2;
  localparam logic [1:0] ACT_SET_LEVEL = 2'd3;

  // Configuration register indexes (byte address divided by four).
  localparam logic [1:0] REG_DEBOUNCE     = 2'd0;
  localparam logic [1:0] REG_REPEAT_DELAY = 2'd1;
  localparam logic [1:0] REG_BLINK_RATE   = 2'd2;

  localparam logic [5:0] DEBOUNCE_RESET     = 6'd30;
  localparam logic [9:0] REPEAT_DELAY_RESET = 10'd300;
  localparam logic [7:0] BLINK_RATE_RESET   = 8'd0;

  localparam logic [7:0] RPT_COUNT_RESET = 8'd60;
  localparam logic [7:0] LONG_PRESS_MAX  = 8'd50;

  localparam logic [7:0] FRAME_START = 8'h24;
  localparam logic [7:0] FRAME_END   = 8'h23;

  // One item's worth of results, held until the last one has been transferred.
  typedef struct packed {
    logic       two_tx;
    logic [7:0] tx0;
    logic [7:0] tx1;
    logic       power;
    logic [7:0] level;
    logic       led;
    logic       toggled;
    logic       long_press;
  } res_t;

  // Received byte scaled by 200/150, i.e. floor(4c/3), clamped to 1..255.
  // The division by three is a multiplication by 683/2048, exact below 1024.
  function automatic logic [7:0] scale_level(input logic [7:0] c);
    logic [19:0] prod;
    logic [8:0]  q;
    prod = 20'({c, 2'b00}) * 20'd683;
    q    = prod[19:11];
    if (q == 9'd0) begin
      return 8'd1;
    end else if (q > 9'd255) begin
      return 8'd255;
    end else begin
      return q[7:0];
    end
  endfunction

  // Bar byte: (level + 30) / 30 with the power flag in bit 6.
  // The division by thirty is a multiplication by 2185/65536, exact below 286.
  function automatic logic [7:0] bar_byte(input logic [7:0] lvl, input logic pwr);
    logic [8:0]  y;
    logic [20:0] prod;
    y    = 9'(lvl) + 9'd30;
    prod = 21'(y) * 21'd2185;
    return {1'b0, pwr, 2'b00, prod[19:16]};
  endfunction

  // Level byte: 0x80 | level >> 1, with 0x81 standing in for 0x80.
  function automatic logic [7:0] level_byte(input logic [7:0] lvl);
    if (lvl[7:1] == 7'd0) begin
      return 8'h81;
    end else begin
      return {1'b1, lvl[7:1]};
    end
  endfunction

endpackage

// ===== rtl/dbl_button.sv =====
// Button debounce and auto-repeat tracker; state advances on accepted ticks.
// Depends on dbl_pkg.
`timescale 1ns / 1ps
module dbl_button (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       sample_i,
  input  logic [5:0] debounce_ms_i,
  input  logic [9:0] repeat_delay_ms_i,
  output logic       toggled_o,
  output logic       long_press_o
);
  import dbl_pkg::*;

  logic        prev_q, prev_d;
  logic        stable_q, stable_d;
  logic [5:0]  sage_q, sage_d;
  logic [10:0] rage_q, rage_d;
  logic [7:0]  rcnt_q, rcnt_d;
  logic        rpt_q, rpt_d;
  logic [10:0] limit;

  always_comb begin
    prev_d       = sample_i;
    stable_d     = stable_q;
    rcnt_d       = rcnt_q;
    rpt_d        = rpt_q;
    toggled_o    = 1'b0;
    long_press_o = 1'b0;
    limit        = rpt_q ? {1'b0, repeat_delay_ms_i} : {repeat_delay_ms_i, 1'b0};

    if (sample_i != prev_q) begin
      sage_d = 6'd0;
    end else if (sage_q != 6'd63) begin
      sage_d = sage_q + 6'd1;
    end else begin
      sage_d = sage_q;
    end
    rage_d = (rage_q != 11'd2047) ? rage_q + 11'd1 : rage_q;

    if (sage_d > debounce_ms_i) begin
      if (sample_i != stable_q) begin
        stable_d = sample_i;
        if (!sample_i) begin
          rage_d = 11'd0;
          rcnt_d = 8'd0;
        end else if (rcnt_q != 8'd0) begin
          long_press_o = (rcnt_q <= LONG_PRESS_MAX) && (rcnt_q > 8'd1);
        end else begin
          toggled_o = 1'b1;
          rpt_d     = 1'b0;
        end
      end else if (!stable_q && (rage_d > limit)) begin
        rage_d = 11'd0;
        if (rcnt_q != 8'd255) begin
          rcnt_d = rcnt_q + 8'd1;
        end
        rpt_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= 1'b0;
      stable_q <= 1'b0;
      sage_q   <= 6'd63;
      rage_q   <= 11'd0;
      rcnt_q   <= RPT_COUNT_RESET;
      rpt_q    <= 1'b0;
    end else if (en_i) begin
      prev_q   <= prev_d;
      stable_q <= stable_d;
      sage_q   <= sage_d;
      rage_q   <= rage_d;
      rcnt_q   <= rcnt_d;
      rpt_q    <= rpt_d;
    end
  end

endmodule

// ===== rtl/dbl_link.sv =====
// Link frame parser: start byte, level byte, end byte.
// Depends on dbl_pkg for the frame bytes and the level scaling.
`timescale 1ns / 1ps
module dbl_link (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [7:0] rx_byte_i,
  output logic       level_wr_o,
  output logic [7:0] level_o
);
  import dbl_pkg::*;

  localparam logic [1:0] PS_START = 2'd0;
  localparam logic [1:0] PS_LEVEL = 2'd1;
  localparam logic [1:0] PS_END   = 2'd2;

  logic [1:0] ps_q, ps_d;

  assign level_o = scale_level(rx_byte_i);

  always_comb begin
    level_wr_o = 1'b0;
    case (ps_q)
      PS_LEVEL: begin
        level_wr_o = 1'b1;
        ps_d       = PS_END;
      end
      PS_END: begin
        ps_d = (rx_byte_i == FRAME_END) ? PS_START : PS_END;
      end
      default: begin
        ps_d = (rx_byte_i == FRAME_START) ? PS_LEVEL : PS_START;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q <= PS_START;
    end else if (en_i) begin
      ps_q <= ps_d;
    end
  end

endmodule

// ===== rtl/dbl_out.sv =====
// Result buffer: holds one item's results and hands them out one transfer at a time.
// Depends on dbl_pkg for the result bundle type.
`timescale 1ns / 1ps
module dbl_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  dbl_pkg::res_t       res_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                kind_o,
  output logic [7:0]          tx_byte_o,
  output logic                last_o,
  output logic                power_state_o,
  output logic [7:0]          light_level_o,
  output logic                led_on_o,
  output logic                toggled_o,
  output logic                long_press_o
);
  import dbl_pkg::*;

  logic       valid_q;
  logic [1:0] idx_q;
  res_t       res_q;

  // Index 0 and 1 are the two link bytes, index 2 the closing status result.
  assign out_valid_o   = valid_q;
  assign kind_o        = (idx_q != 2'd2);
  assign last_o        = (idx_q == 2'd2);
  assign tx_byte_o     = (idx_q == 2'd0) ? res_q.tx0 :
                         (idx_q == 2'd1) ? res_q.tx1 : 8'd0;
  assign power_state_o = res_q.power;
  assign light_level_o = res_q.level;
  assign led_on_o      = res_q.led;
  assign toggled_o     = res_q.toggled;
  assign long_press_o  = res_q.long_press;
  assign free_o        = !valid_q || (out_ready_i && last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd2;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= res_i.two_tx ? 2'd0 : 2'd2;
    end else if (valid_q && out_ready_i) begin
      if (last_o) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== rtl/dimmer_button_and_link_controller_core.sv =====
// Top level of the dimmer button and link controller.
// Depends on dbl_pkg, dbl_button, dbl_link and dbl_out.
`timescale 1ns / 1ps
// An item transferred on the input channel is held in an input register and is
// processed from there in a single pass: the button debounce and repeat
// logic, the link frame parser, the pending-value update, the apply check and the
// blink timer all settle combinationally and land together in a result buffer.
// Each item gives one status result, preceded by two link bytes (bar byte, then
// level byte) whenever the pending power or level differed from the applied one.
// Every result is one output transfer, so an item occupies the output for one or
// three transfers; the output port sets the sustained rate: one item per cycle
// without link bytes while the receiver stays ready; with link bytes, the next item
// is loaded only as the last result of the one before is taken. An item passes
// through the input register and then the result buffer before its first result
// is offered. The input register takes the next item while results are still
// waiting, so the input is held off only once both the input register and the
// result buffer are occupied. Configuration is an APB-style port with the debounce
// time at byte 0, the repeat delay at byte 4 and the blink rate at byte 8; pready
// is always high and writes should be made only while the block is idle.
module dimmer_button_and_link_controller_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic        button_level_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        power_on_i,
  input  logic [7:0]  level_i,
  // Output channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic        power_state_o,
  output logic [7:0]  light_level_o,
  output logic        led_on_o,
  output logic        toggled_o,
  output logic        long_press_o
);
  import dbl_pkg::*;

  // Configuration registers.
  logic [5:0]  debounce_q;
  logic [9:0]  repeat_delay_q;
  logic [7:0]  blink_rate_q;
  logic        cfg_wr;

  // Input register.
  logic        in_vld_q;
  logic [1:0]  act_q;
  logic        btn_q;
  logic [7:0]  rx_q;
  logic        pwr_in_q;
  logic [7:0]  lvl_in_q;

  // Controller state.
  logic        pend_pwr_q, pend_pwr_d;
  logic [7:0]  pend_lvl_q, pend_lvl_d;
  logic        app_pwr_q;
  logic [7:0]  app_lvl_q;
  logic [12:0] blink_age_q, blink_age_d;
  logic        led_q, led_d;

  logic        load;
  logic        out_free;
  logic        is_tick;
  logic        btn_toggled;
  logic        btn_long;
  logic        link_wr;
  logic [7:0]  link_lvl;
  logic        apply;
  logic [12:0] age_inc;
  res_t        res;

  // ---------------------------------------------------------------------------
  // Configuration port. A write lands on the access cycle; reads are immediate.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q     <= DEBOUNCE_RESET;
      repeat_delay_q <= REPEAT_DELAY_RESET;
      blink_rate_q   <= BLINK_RATE_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_DEBOUNCE:     debounce_q     <= pwdata[5:0];
        REG_REPEAT_DELAY: repeat_delay_q <= pwdata[9:0];
        REG_BLINK_RATE:   blink_rate_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DEBOUNCE:     prdata = {26'd0, debounce_q};
      REG_REPEAT_DELAY: prdata = {22'd0, repeat_delay_q};
      REG_BLINK_RATE:   prdata = {24'd0, blink_rate_q};
      default:          prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register. It refills in the same cycle that its item moves on.
  // ---------------------------------------------------------------------------
  assign load       = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q    <= action_i;
      btn_q    <= button_level_i;
      rx_q     <= rx_byte_i;
      pwr_in_q <= power_on_i;
      lvl_in_q <= level_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Single processing pass. Sub-blocks only commit their state on a load.
  // ---------------------------------------------------------------------------
  assign is_tick = (act_q == ACT_TICK);

  dbl_button u_button (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (load && is_tick),
    .sample_i          (btn_q),
    .debounce_ms_i     (debounce_q),
    .repeat_delay_ms_i (repeat_delay_q),
    .toggled_o         (btn_toggled),
    .long_press_o      (btn_long)
  );

  dbl_link u_link (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (load && (act_q == ACT_LINK_BYTE)),
    .rx_byte_i  (rx_q),
    .level_wr_o (link_wr),
    .level_o    (link_lvl)
  );

  // Pending values: a short press inverts the applied power, the link parser
  // and the set requests overwrite their field directly.
  always_comb begin
    pend_pwr_d = pend_pwr_q;
    pend_lvl_d = pend_lvl_q;
    case (act_q)
      ACT_TICK: begin
        if (btn_toggled) begin
          pend_pwr_d = !app_pwr_q;
        end
      end
      ACT_LINK_BYTE: begin
        if (link_wr) begin
          pend_lvl_d = link_lvl;
        end
      end
      ACT_SET_POWER: pend_pwr_d = pwr_in_q;
      default:       pend_lvl_d = lvl_in_q;
    endcase
  end

  assign apply = (pend_pwr_d != app_pwr_q) || (pend_lvl_d != app_lvl_q);

  // Blink timer: saturating age, toggles the LED once it passes 16 ticks per unit
  // of the blink rate. Only ticks move it.
  always_comb begin
    blink_age_d = blink_age_q;
    led_d       = led_q;
    age_inc     = (blink_age_q != 13'h1FFF) ? blink_age_q + 13'd1 : blink_age_q;
    if (is_tick) begin
      blink_age_d = age_inc;
      if ((blink_rate_q != 8'd0) && (age_inc > {1'b0, blink_rate_q, 4'b0000})) begin
        blink_age_d = 13'd0;
        led_d       = !led_q;
      end
    end
  end

  // The link bytes carry the newly applied values, which are the pending ones.
  always_comb begin
    res.two_tx     = apply;
    res.tx0        = bar_byte(pend_lvl_d, pend_pwr_d);
    res.tx1        = level_byte(pend_lvl_d);
    res.power      = pend_pwr_d;
    res.level      = pend_lvl_d;
    res.led        = led_d;
    res.toggled    = is_tick && btn_toggled;
    res.long_press = is_tick && btn_long;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_pwr_q  <= 1'b0;
      pend_lvl_q  <= 8'd0;
      app_pwr_q   <= 1'b0;
      app_lvl_q   <= 8'd0;
      blink_age_q <= 13'd0;
      led_q       <= 1'b0;
    end else if (load) begin
      pend_pwr_q  <= pend_pwr_d;
      pend_lvl_q  <= pend_lvl_d;
      app_pwr_q   <= pend_pwr_d;
      app_lvl_q   <= pend_lvl_d;
      blink_age_q <= blink_age_d;
      led_q       <= led_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result buffer and output sequencing.
  // ---------------------------------------------------------------------------
  dbl_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .res_i         (res),
    .free_o        (out_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .tx_byte_o     (tx_byte_o),
    .last_o        (last_o),
    .power_state_o (power_state_o),
    .light_level_o (light_level_o),
    .led_on_o      (led_on_o),
    .toggled_o     (toggled_o),
    .long_press_o  (long_press_o)
  );

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // A link byte is never the final result of an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> !last_o)
    else $error("link byte marked as last result");

  // The level byte never goes out as a bare 0x80.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o && tx_byte_o[7] |-> tx_byte_o != 8'h80)
    else $error("level byte 0x80 transmitted");

  // An item moved into the result buffer is offered on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o)
    else $error("loaded item not presented on the output");

  // A release cannot be both a short and a long press.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(toggled_o && long_press_o))
    else $error("short and long press flagged together");

endmodule

// ===== tb/dimmer_shadow_pkg.sv =====
// Cycle-free shadow of the dimmer button and link controller with a result queue and checker.
// Depends on dbl_pkg for the item codes, register indexes and reset values.
`timescale 1ns / 1ps
package dimmer_shadow_pkg;
  import dbl_pkg::*;

  localparam bit KIND_STATUS = 1'b0;
  localparam bit KIND_TX     = 1'b1;

  typedef enum bit [1:0] {
    WAIT_START = 2'd0,
    WAIT_LEVEL = 2'd1,
    WAIT_END   = 2'd2
  } frame_state_e;

  typedef struct packed {
    bit       kind;
    bit [7:0] tx_byte;
    bit       last;
    bit       power_state;
    bit [7:0] light_level;
    bit       led_on;
    bit       toggled;
    bit       long_press;
  } dimmer_result_t;

  class dimmer_shadow;
    bit [5:0]       debounce_ms;
    bit [9:0]       repeat_delay_ms;
    bit [7:0]       blink_rate;
    bit             prev_sample;
    bit             stable_level;
    bit [5:0]       stable_age;
    bit [10:0]      repeat_age;
    bit [7:0]       repeat_count;
    bit             repeating;
    frame_state_e   frame_state;
    bit             pend_power;
    bit [7:0]       pend_level;
    bit             appl_power;
    bit [7:0]       appl_level;
    bit [12:0]      blink_age;
    bit             led;
    dimmer_result_t due_results[$];
    int             errors;

    function new();
      debounce_ms     = DEBOUNCE_RESET;
      repeat_delay_ms = REPEAT_DELAY_RESET;
      blink_rate      = BLINK_RATE_RESET;
      prev_sample     = 1'b0;
      stable_level    = 1'b0;
      stable_age      = 6'd63;
      repeat_age      = '0;
      repeat_count    = RPT_COUNT_RESET;
      repeating       = 1'b0;
      frame_state     = WAIT_START;
      pend_power      = 1'b0;
      pend_level      = '0;
      appl_power      = 1'b0;
      appl_level      = '0;
      blink_age       = '0;
      led             = 1'b0;
      errors          = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_DEBOUNCE:     debounce_ms     = value[5:0];
        REG_REPEAT_DELAY: repeat_delay_ms = value[9:0];
        REG_BLINK_RATE:   blink_rate      = value[7:0];
        default: ;
      endcase
    endfunction

    function bit [31:0] reg_value(logic [1:0] idx);
      case (idx)
        REG_DEBOUNCE:     return 32'(debounce_ms);
        REG_REPEAT_DELAY: return 32'(repeat_delay_ms);
        REG_BLINK_RATE:   return 32'(blink_rate);
        default:          return 32'd0;
      endcase
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction

    // Debounce, then press/release handling and hold auto-repeat.
    function void tick_button(bit s, output bit tog, output bit lp);
      int limit;
      tog = 1'b0;
      lp  = 1'b0;
      if (s != prev_sample) stable_age = '0;
      else if (stable_age < 6'd63) stable_age++;
      if (repeat_age < 11'd2047) repeat_age++;
      if (int'(stable_age) > int'(debounce_ms)) begin
        if (s != stable_level) begin
          stable_level = s;
          if (!s) begin
            repeat_age   = '0;
            repeat_count = '0;
          end else if (repeat_count != 8'd0) begin
            if (repeat_count <= LONG_PRESS_MAX && repeat_count > 8'd1) lp = 1'b1;
          end else begin
            tog       = 1'b1;
            repeating = 1'b0;
          end
        end else if (!stable_level) begin
          limit = repeating ? int'(repeat_delay_ms) : 2 * int'(repeat_delay_ms);
          if (int'(repeat_age) > limit) begin
            repeat_age = '0;
            if (repeat_count < 8'd255) repeat_count++;
            repeating = 1'b1;
          end
        end
      end
      if (tog) pend_power = ~appl_power;
      prev_sample = s;
    endfunction

    function void take_link_byte(bit [7:0] c);
      int lv;
      if (frame_state == WAIT_LEVEL) begin
        lv = int'(c) * 200 / 150;
        if (lv == 0) lv = 1;
        if (lv > 255) lv = 255;
        pend_level  = 8'(lv);
        frame_state = WAIT_END;
      end else if (frame_state == WAIT_END) begin
        if (c == FRAME_END) frame_state = WAIT_START;
      end else begin
        frame_state = (c == FRAME_START) ? WAIT_LEVEL : WAIT_START;
      end
    endfunction

    // Notes one accepted input item and queues the results it must cause.
    function void accept_item(bit [1:0] act, bit btn, bit [7:0] rx, bit pwr, bit [7:0] lvl);
      bit             tog;
      bit             lp;
      int             n;
      bit [7:0]       tx[2];
      dimmer_result_t r;
      tog = 1'b0;
      lp  = 1'b0;
      n   = 0;
      case (act)
        ACT_TICK:      tick_button(btn, tog, lp);
        ACT_LINK_BYTE: take_link_byte(rx);
        ACT_SET_POWER: pend_power = pwr;
        default:       pend_level = lvl;
      endcase
      if (pend_power != appl_power || pend_level != appl_level) begin
        appl_power = pend_power;
        appl_level = pend_level;
        tx[0] = 8'((int'(appl_level) + 30) / 30) | (appl_power ? 8'h40 : 8'h00);
        tx[1] = 8'h80 | (appl_level >> 1);
        if (tx[1] == 8'h80) tx[1] = 8'h81;
        n = 2;
      end
      if (act == ACT_TICK) begin
        if (blink_age < 13'd8191) blink_age++;
        if (blink_rate != 8'd0 && int'(blink_age) > int'(blink_rate) * 16) begin
          blink_age = '0;
          led       = ~led;
        end
      end
      for (int k = 0; k <= n; k++) begin
        r.kind        = (k < n) ? KIND_TX : KIND_STATUS;
        r.tx_byte     = (k < n) ? tx[k] : 8'd0;
        r.last        = (k == n);
        r.power_state = appl_power;
        r.light_level = appl_level;
        r.led_on      = led;
        r.toggled     = tog;
        r.long_press  = lp;
        due_results.push_back(r);
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(dimmer_result_t got);
      dimmer_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result with none expected, actual kind %0d tx_byte %0d last %0d",
                 $time, got.kind, got.tx_byte, got.last);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("tx_byte", want.tx_byte, got.tx_byte);
      compare_field("last", want.last, got.last);
      compare_field("power_state", want.power_state, got.power_state);
      compare_field("light_level", want.light_level, got.light_level);
      compare_field("led_on", want.led_on, got.led_on);
      compare_field("toggled", want.toggled, got.toggled);
      compare_field("long_press", want.long_press, got.long_press);
    endfunction
  endclass

endpackage

// ===== tb/dimmer_button_and_link_controller_core_tb.sv =====
// Self-checking testbench for dimmer_button_and_link_controller_core.
// Depends on dbl_pkg and on the shadow model and checker in dimmer_shadow_pkg.
`timescale 1ns / 1ps
module dimmer_button_and_link_controller_core_tb;
  import dbl_pkg::*;
  import dimmer_shadow_pkg::*;

  // Clock, reset and every block input start at a known value.
  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [3:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i       = ACT_TICK;
  logic        button_level_i = 1'b1;
  logic [7:0]  rx_byte_i      = '0;
  logic        power_on_i     = 1'b0;
  logic [7:0]  level_i        = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic        kind_o;
  logic [7:0]  tx_byte_o;
  logic        last_o;
  logic        power_state_o;
  logic [7:0]  light_level_o;
  logic        led_on_o;
  logic        toggled_o;
  logic        long_press_o;

  dimmer_shadow   sb;
  dimmer_result_t seen;

  // Percentages of cycles in which the sender is idle and the receiver stalls.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_request   = 1'b0;
  int items_sent     = 0;

  dimmer_button_and_link_controller_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .button_level_i (button_level_i),
    .rx_byte_i      (rx_byte_i),
    .power_on_i     (power_on_i),
    .level_i        (level_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .tx_byte_o      (tx_byte_o),
    .last_o         (last_o),
    .power_state_o  (power_state_o),
    .light_level_o  (light_level_o),
    .led_on_o       (led_on_o),
    .toggled_o      (toggled_o),
    .long_press_o   (long_press_o)
  );

  // An 8 ns clock: four nanoseconds high, four low.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver. Ready changes only at the falling edge. A hold-off request keeps ready low
  // for a long stretch, counted here in cycles, so that the block fills up and pushes
  // back on its input; otherwise ready is dropped at random at the phase's stall rate.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_left    = 80;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  // Result monitor. Every output transfer, seen at the rising edge, is checked against
  // the oldest expected result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.kind        = kind_o;
      seen.tx_byte     = tx_byte_o;
      seen.last        = last_o;
      seen.power_state = power_state_o;
      seen.light_level = light_level_o;
      seen.led_on      = led_on_o;
      seen.toggled     = toggled_o;
      seen.long_press  = long_press_o;
      sb.check_result(seen);
    end
  end

  // Offers one item. An idle gap, if the phase calls for one, is taken first with valid
  // low; then valid and the payload are raised at a falling edge and held until the
  // transfer happens at a rising edge, at which point the shadow model takes the item.
  // Valid is left high afterwards, so back-to-back items never drop it in between.
  task automatic send_item(input logic [1:0] act, input logic btn, input logic [7:0] rx,
                           input logic pwr, input logic [7:0] lvl);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99, 0) < send_idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    button_level_i <= btn;
    rx_byte_i      <= rx;
    power_on_i     <= pwr;
    level_i        <= lvl;
    do @(posedge clk_i); while (!in_ready_o);
    sb.accept_item(act, btn, rx, pwr, lvl);
    items_sent++;
  endtask

  // The fields that an item does not use carry random values.
  task automatic tick(input logic btn);
    send_item(ACT_TICK, btn, 8'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic link_byte(input logic [7:0] c);
    send_item(ACT_LINK_BYTE, 1'($urandom), c, 1'($urandom), 8'($urandom));
  endtask

  task automatic set_power(input logic p);
    send_item(ACT_SET_POWER, 1'($urandom), 8'($urandom), p, 8'($urandom));
  endtask

  task automatic set_level(input logic [7:0] l);
    send_item(ACT_SET_LEVEL, 1'($urandom), 8'($urandom), 1'($urandom), l);
  endtask

  // Drops valid at the next falling edge, so that a held item is not transferred twice,
  // and waits until every expected result has been transferred. Each item causes at
  // least one result, so the block is idle once the queue is empty; spare cycles
  // follow all the same.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes a register with a setup and an access cycle, then reads it back the same way.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd != sb.reg_value(idx)) begin
      $display("%0t: register %0d read back, expected %0d, actual %0d",
               $time, idx, sb.reg_value(idx), rd);
      sb.errors++;
    end
  endtask

  task automatic configure(input int deb, input int dly, input int rate);
    write_reg(REG_DEBOUNCE, 32'(deb));
    write_reg(REG_REPEAT_DELAY, 32'(dly));
    write_reg(REG_BLINK_RATE, 32'(rate));
  endtask

  // One random sequence. Most are well formed (clean presses of either length, whole
  // frames with random levels, set requests); the rest are contact bounce, broken
  // frames and fully random items.
  task automatic random_sequence();
    int       pick;
    int       deb;
    int       dly;
    int       hold;
    logic [7:0] v;
    deb  = int'(sb.debounce_ms);
    dly  = int'(sb.repeat_delay_ms);
    pick = $urandom_range(99, 0);
    if (pick < 35) begin
      if ($urandom_range(3, 0) == 0) repeat ($urandom_range(3, 1)) tick(1'($urandom));
      if ($urandom_range(1, 0) == 1) begin
        // Short enough that no repeat is counted, so the release toggles power.
        hold = deb + 2 + $urandom_range(2, 0);
      end else begin
        hold = deb + 2 + 2 * dly + dly * $urandom_range(6, 0) + $urandom_range(3, 0);
      end
      repeat (hold) tick(1'b0);
      repeat (deb + 2 + $urandom_range(3, 0)) tick(1'b1);
    end else if (pick < 55) begin
      case ($urandom_range(3, 0))
        0:       v = 8'h00;
        1:       v = 8'hff;
        default: v = 8'($urandom);
      endcase
      link_byte(FRAME_START);
      link_byte(v);
      if ($urandom_range(3, 0) == 0) link_byte(8'($urandom));
      if ($urandom_range(7, 0) != 0) link_byte(FRAME_END);
    end else if (pick < 70) begin
      if ($urandom_range(1, 0) == 1) set_power(1'($urandom));
      else set_level(8'($urandom));
    end else if (pick < 85) begin
      repeat ($urandom_range(4, 1)) tick(1'($urandom));
    end else begin
      send_item(2'($urandom), 1'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int phase_end;
    sb = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset settings. The frame parser is walked through a stray
    // end byte, a start byte taken as a level, junk while waiting for the end, and
    // levels that clamp to one and to 255. Set requests reach the level byte that must
    // avoid 0x80 and the bar byte with the power flag.
    tick(1'b0);
    tick(1'b1);
    link_byte(FRAME_END);
    link_byte(FRAME_START);
    link_byte(8'h00);
    link_byte(FRAME_END);
    set_level(8'hff);
    set_power(1'b1);
    link_byte(FRAME_START);
    link_byte(8'hff);
    link_byte(FRAME_END);
    link_byte(FRAME_START);
    link_byte(FRAME_START);
    link_byte(8'h55);
    link_byte(FRAME_END);
    set_level(8'h00);
    set_power(1'b0);
    set_level(8'h02);
    set_level(8'h03);
    wait_drained();

    // No debounce, a zero repeat delay so that a held button repeats on every tick, and
    // the fastest blink. The first release after reset must neither toggle nor flag a
    // long press; then a short press, a long press, a press with only one repeat, and a
    // hold of more than fifty repeats, whose release flags nothing.
    configure(0, 0, 1);
    tick(1'b1);
    repeat (2) tick(1'b0);
    repeat (2) tick(1'b1);
    repeat (5) tick(1'b0);
    repeat (2) tick(1'b1);
    repeat (3) tick(1'b0);
    repeat (2) tick(1'b1);
    repeat (56) tick(1'b0);
    repeat (2) tick(1'b1);
    wait_drained();

    // Random part in four idling phases, each under settings of its own.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      wait_drained();
      if (ph == 0) configure(0, 1, 0);
      else configure($urandom_range(3, 0), $urandom_range(4, 1), $urandom_range(3, 1));
      if (ph == 0) begin
        // The receiver holds off while the sender keeps offering items, then the sender
        // waits until everything has drained.
        hold_request = 1'b1;
        repeat (10) set_level(8'($urandom));
        wait_drained();
      end
      phase_end = items_sent + 14;
      while (items_sent < phase_end) begin
        random_sequence();
        if (ph == 1 && items_sent >= phase_end - 7 && sb.outstanding() > 0) begin
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("dimmer_button_and_link_controller_core test passed");
    end else begin
      $display("dimmer_button_and_link_controller_core test failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake: 1 ms, far beyond the slowest correct run.
  initial begin
    #1000000;
    $display("dimmer_button_and_link_controller_core test failed");
    $finish;
  end

endmodule
